// ===== hdl/fdel_pkg.sv =====
package fdel_pkg;

    localparam int NAME_BYTES = 256;
    localparam int ADDR_W     = $clog2(NAME_BYTES);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int POS_W      = 12;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ENTRY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_PENDING = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;
    localparam logic [1:0] ST_BYTE    = 2'd3;

    localparam logic [7:0] MARK_END     = 8'h00;
    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_LFN     = 8'h0F;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;

    localparam int LFN_CHARS = 13;
    localparam int SUM_BYTES = 11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROC,
        S_SUM,
        S_LFN_CHAR,
        S_LFN_BYTE,
        S_LEN_RD,
        S_LEN_CHK,
        S_SHORT_WR,
        S_RDNAME,
        S_FIN
    } state_t;

    typedef logic [4:0] char_at_t [0:LFN_CHARS-1];

    localparam char_at_t CHAR_AT = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

    function automatic logic [1:0] utf8_count(input logic [15:0] c);
        logic [1:0] n;
        if (c < 16'h0080)
        begin
            n = 2'd1;
        end
        else if (c < 16'h0800)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [15:0] c, input logic [1:0] n,
                                             input logic [1:0] k);
        logic [7:0] v;
        v = c[7:0];
        if (n == 2'd2)
        begin
            v = (k == 2'd0) ? (8'hC0 | {3'b000, c[10:6]}) : (8'h80 | {2'b00, c[5:0]});
        end
        else if (n == 2'd3)
        begin
            case (k)
                2'd0:    v = 8'hE0 | {4'b0000, c[15:12]};
                2'd1:    v = 8'h80 | {2'b00, c[11:6]};
                default: v = 8'h80 | {2'b00, c[5:0]};
            endcase
        end
        return v;
    endfunction

endpackage

// ===== hdl/fdel_ram.sv =====
module fdel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/fat_directory_entry_lister.sv =====
// Channel  Dir  tuser          tdata
// s_*      in   command[1:0]   entry_word, word_position, target_index, name_position
// m_*      out  status[1:0]    first_cluster, name_length, long_name_used, name_byte
//
// One item at a time; start, partial quarters, idle commands and entries after the end go
// straight to the result state, while a name read, a deleted entry or the end marker pass
// a processing state first. A long-name piece steps through its 13 characters and writes
// each UTF-8 byte in turn, unless its checksum is rejected. A short entry sums 11 name bytes;
// the wanted entry then scans the long name up to its terminator, or writes a dotted 8.3 name.
// Reset clears the name store through per-byte valid bits at once; no sweep is needed.
// A result waits in the output register while the next item is taken.
module fat_directory_entry_lister (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // entry_word[63:0], word_position[65:64],
                                   // target_index[81:66], name_position[89:82]
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // first_cluster[31:0], name_length[39:32],
                                   // long_name_used[40], name_byte[48:41]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = fdel_pkg::ADDR_W;
    localparam int LW = fdel_pkg::LEN_W;
    localparam int PW = fdel_pkg::POS_W;

    fdel_pkg::state_t state_reg, state_next;

    logic [63:0] quarters_reg [0:3];

    logic [7:0]  exp_sum_reg, exp_sum_next;
    logic        active_reg, active_next;
    logic [15:0] listed_reg, listed_next;
    logic [15:0] wanted_reg, wanted_next;
    logic        finished_reg, finished_next;
    logic [fdel_pkg::NAME_BYTES-1:0] valid_reg, valid_next;
    logic        valid_q_reg, valid_q_next;
    logic [3:0]  cidx_reg, cidx_next;
    logic [1:0]  k_reg, k_next;
    logic [1:0]  n_reg, n_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [3:0]  sidx_reg, sidx_next;
    logic        dot_reg, dot_next;
    logic [7:0]  sum_reg, sum_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_cluster_reg, res_cluster_next;
    logic [7:0]  res_len_reg, res_len_next;
    logic        res_long_reg, res_long_next;
    logic [7:0]  res_byte_reg, res_byte_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    logic [1:0]  command;
    logic [63:0] entry_word;
    logic [1:0]  word_position;
    logic [15:0] target_index;
    logic [7:0]  name_position;
    logic        accept;

    logic [255:0] ent;
    logic [7:0]   b0, attr, b13;
    logic [3:0]   cidx_sel;
    logic [4:0]   at;
    logic [15:0]  ch;
    logic [7:0]   sb;
    logic [7:0]   sum_step;
    logic         pos_ok;
    logic [7:0]   rd_byte;

    assign command       = s_tuser;
    assign entry_word    = s_tdata[63:0];
    assign word_position = s_tdata[65:64];
    assign target_index  = s_tdata[81:66];
    assign name_position = s_tdata[89:82];

    assign s_tready = (state_reg == fdel_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign ent      = {quarters_reg[3], quarters_reg[2], quarters_reg[1], quarters_reg[0]};
    assign b0       = ent[7:0];
    assign attr     = ent[95:88];
    assign b13      = ent[111:104];
    assign cidx_sel = (cidx_reg < 4'(fdel_pkg::LFN_CHARS)) ? cidx_reg : 4'd0;
    assign at       = fdel_pkg::CHAR_AT[cidx_sel];
    assign ch       = {ent[{at + 5'd1, 3'b000} +: 8], ent[{at, 3'b000} +: 8]};
    assign sb       = ent[{1'b0, sidx_reg, 3'b000} +: 8];
    assign sum_step = {sum_reg[0], sum_reg[7:1]} + sb;
    assign pos_ok   = !pos_reg[PW-1]
                      && (pos_reg[PW-2:0] < (PW-1)'(fdel_pkg::NAME_BYTES));
    assign rd_byte  = valid_q_reg ? rdata : 8'd0;

    fdel_ram #(
        .WIDTH (8),
        .DEPTH (fdel_pkg::NAME_BYTES)
    ) u_name_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept && (command == fdel_pkg::CMD_ENTRY))
        begin
            quarters_reg[word_position] <= entry_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fdel_pkg::S_IDLE;
            exp_sum_reg     <= '0;
            active_reg      <= 1'b0;
            listed_reg      <= '0;
            wanted_reg      <= '0;
            finished_reg    <= 1'b0;
            valid_reg       <= '0;
            valid_q_reg     <= 1'b0;
            cidx_reg        <= '0;
            k_reg           <= '0;
            n_reg           <= '0;
            pos_reg         <= '0;
            sidx_reg        <= '0;
            dot_reg         <= 1'b0;
            sum_reg         <= '0;
            len_reg         <= '0;
            res_status_reg  <= fdel_pkg::ST_PENDING;
            res_cluster_reg <= '0;
            res_len_reg     <= '0;
            res_long_reg    <= 1'b0;
            res_byte_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            exp_sum_reg     <= exp_sum_next;
            active_reg      <= active_next;
            listed_reg      <= listed_next;
            wanted_reg      <= wanted_next;
            finished_reg    <= finished_next;
            valid_reg       <= valid_next;
            valid_q_reg     <= valid_q_next;
            cidx_reg        <= cidx_next;
            k_reg           <= k_next;
            n_reg           <= n_next;
            pos_reg         <= pos_next;
            sidx_reg        <= sidx_next;
            dot_reg         <= dot_next;
            sum_reg         <= sum_next;
            len_reg         <= len_next;
            res_status_reg  <= res_status_next;
            res_cluster_reg <= res_cluster_next;
            res_len_reg     <= res_len_next;
            res_long_reg    <= res_long_next;
            res_byte_reg    <= res_byte_next;
            m_tvalid_reg    <= m_tvalid_next;
            m_tdata_reg     <= m_tdata_next;
            m_tuser_reg     <= m_tuser_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        exp_sum_next     = exp_sum_reg;
        active_next      = active_reg;
        listed_next      = listed_reg;
        wanted_next      = wanted_reg;
        finished_next    = finished_reg;
        valid_next       = valid_reg;
        valid_q_next     = valid_q_reg;
        cidx_next        = cidx_reg;
        k_next           = k_reg;
        n_next           = n_reg;
        pos_next         = pos_reg;
        sidx_next        = sidx_reg;
        dot_next         = dot_reg;
        sum_next         = sum_reg;
        len_next         = len_reg;
        res_status_next  = res_status_reg;
        res_cluster_next = res_cluster_reg;
        res_len_next     = res_len_reg;
        res_long_next    = res_long_reg;
        res_byte_next    = res_byte_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        we               = 1'b0;
        waddr            = pos_reg[AW-1:0];
        wdata            = 8'd0;
        re               = 1'b0;
        raddr            = len_reg[AW-1:0];

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            fdel_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next  = fdel_pkg::ST_PENDING;
                    res_cluster_next = '0;
                    res_len_next     = '0;
                    res_long_next    = 1'b0;
                    res_byte_next    = '0;
                    state_next       = fdel_pkg::S_FIN;
                    case (command)
                        fdel_pkg::CMD_START:
                        begin
                            wanted_next   = target_index;
                            listed_next   = '0;
                            active_next   = 1'b0;
                            exp_sum_next  = '0;
                            finished_next = 1'b0;
                            valid_next    = '0;
                        end
                        fdel_pkg::CMD_ENTRY:
                        begin
                            if ((word_position == 2'd3) && !finished_reg)
                            begin
                                state_next = fdel_pkg::S_PROC;
                            end
                        end
                        fdel_pkg::CMD_READ:
                        begin
                            re           = 1'b1;
                            raddr        = AW'(name_position);
                            valid_q_next = valid_reg[AW'(name_position)]
                                           && (16'(name_position) < 16'(fdel_pkg::NAME_BYTES));
                            state_next   = fdel_pkg::S_RDNAME;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            fdel_pkg::S_RDNAME:
            begin
                res_status_next = fdel_pkg::ST_BYTE;
                res_byte_next   = rd_byte;
                state_next      = fdel_pkg::S_FIN;
            end

            fdel_pkg::S_PROC:
            begin
                state_next = fdel_pkg::S_FIN;
                if (b0 == fdel_pkg::MARK_END)
                begin
                    finished_next   = 1'b1;
                    res_status_next = fdel_pkg::ST_END;
                end
                else if (b0 == fdel_pkg::MARK_DELETED)
                begin
                    state_next = fdel_pkg::S_FIN;
                end
                else if (attr == fdel_pkg::ATTR_LFN)
                begin
                    if (b0[6])
                    begin
                        valid_next   = '0;
                        exp_sum_next = b13;
                        active_next  = 1'b1;
                    end
                    if ((b0[6] || active_reg) && (b0[6] || (b13 == exp_sum_reg)))
                    begin
                        pos_next   = (PW'({b0[4:0]}) * PW'(fdel_pkg::LFN_CHARS))
                                     - PW'(fdel_pkg::LFN_CHARS);
                        cidx_next  = '0;
                        state_next = fdel_pkg::S_LFN_CHAR;
                    end
                end
                else
                begin
                    sum_next   = '0;
                    sidx_next  = '0;
                    state_next = fdel_pkg::S_SUM;
                end
            end

            fdel_pkg::S_LFN_CHAR:
            begin
                if (cidx_reg == 4'(fdel_pkg::LFN_CHARS))
                begin
                    state_next = fdel_pkg::S_FIN;
                end
                else if (ch == 16'hFFFF)
                begin
                    cidx_next = cidx_reg + 4'd1;
                end
                else
                begin
                    n_next     = fdel_pkg::utf8_count(ch);
                    k_next     = '0;
                    state_next = fdel_pkg::S_LFN_BYTE;
                end
            end

            fdel_pkg::S_LFN_BYTE:
            begin
                we       = pos_ok;
                wdata    = fdel_pkg::utf8_byte(ch, n_reg, k_reg);
                pos_next = pos_reg + PW'(1);
                if (pos_ok)
                begin
                    valid_next[pos_reg[AW-1:0]] = 1'b1;
                end
                if (k_reg == (n_reg - 2'd1))
                begin
                    cidx_next  = cidx_reg + 4'd1;
                    state_next = fdel_pkg::S_LFN_CHAR;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            fdel_pkg::S_SUM:
            begin
                sum_next  = sum_step;
                sidx_next = sidx_reg + 4'd1;
                if (sidx_reg == 4'(fdel_pkg::SUM_BYTES - 1))
                begin
                    if (active_reg && (sum_step != exp_sum_reg))
                    begin
                        active_next = 1'b0;
                    end
                    state_next = fdel_pkg::S_FIN;
                    if (attr[3])
                    begin
                        active_next = 1'b0;
                    end
                    else if (listed_reg == wanted_reg)
                    begin
                        if (active_reg && (sum_step == exp_sum_reg))
                        begin
                            len_next   = '0;
                            state_next = fdel_pkg::S_LEN_RD;
                        end
                        else
                        begin
                            sidx_next  = '0;
                            dot_next   = 1'b0;
                            pos_next   = '0;
                            state_next = fdel_pkg::S_SHORT_WR;
                        end
                    end
                    else
                    begin
                        listed_next = listed_reg + 16'd1;
                        active_next = 1'b0;
                    end
                end
            end

            fdel_pkg::S_LEN_RD:
            begin
                if (len_reg == LW'(fdel_pkg::NAME_BYTES))
                begin
                    res_status_next  = fdel_pkg::ST_FOUND;
                    res_cluster_next = {ent[175:160], ent[223:208]};
                    res_len_next     = (len_reg > LW'(255)) ? 8'd255 : 8'(len_reg);
                    res_long_next    = 1'b1;
                    finished_next    = 1'b1;
                    state_next       = fdel_pkg::S_FIN;
                end
                else
                begin
                    re           = 1'b1;
                    raddr        = len_reg[AW-1:0];
                    valid_q_next = valid_reg[len_reg[AW-1:0]];
                    state_next   = fdel_pkg::S_LEN_CHK;
                end
            end

            fdel_pkg::S_LEN_CHK:
            begin
                if (rd_byte == 8'd0)
                begin
                    if (len_reg == '0)
                    begin
                        sidx_next  = '0;
                        dot_next   = 1'b0;
                        pos_next   = '0;
                        state_next = fdel_pkg::S_SHORT_WR;
                    end
                    else
                    begin
                        res_status_next  = fdel_pkg::ST_FOUND;
                        res_cluster_next = {ent[175:160], ent[223:208]};
                        res_len_next     = (len_reg > LW'(255)) ? 8'd255 : 8'(len_reg);
                        res_long_next    = 1'b1;
                        finished_next    = 1'b1;
                        state_next       = fdel_pkg::S_FIN;
                    end
                end
                else
                begin
                    len_next   = len_reg + LW'(1);
                    state_next = fdel_pkg::S_LEN_RD;
                end
            end

            fdel_pkg::S_SHORT_WR:
            begin
                if (sidx_reg < 4'd8)
                begin
                    if (sb != fdel_pkg::CHAR_SPACE)
                    begin
                        we        = 1'b1;
                        wdata     = sb;
                        valid_next[pos_reg[AW-1:0]] = 1'b1;
                        pos_next  = pos_reg + PW'(1);
                        sidx_next = sidx_reg + 4'd1;
                    end
                    else
                    begin
                        sidx_next = 4'd8;
                    end
                end
                else if (sidx_reg < 4'(fdel_pkg::SUM_BYTES))
                begin
                    if (!dot_reg && (sidx_reg == 4'd8))
                    begin
                        if (sb != fdel_pkg::CHAR_SPACE)
                        begin
                            we        = 1'b1;
                            wdata     = fdel_pkg::CHAR_DOT;
                            valid_next[pos_reg[AW-1:0]] = 1'b1;
                            pos_next  = pos_reg + PW'(1);
                            dot_next  = 1'b1;
                        end
                        else
                        begin
                            sidx_next = 4'(fdel_pkg::SUM_BYTES);
                        end
                    end
                    else if (sb != fdel_pkg::CHAR_SPACE)
                    begin
                        we        = 1'b1;
                        wdata     = sb;
                        valid_next[pos_reg[AW-1:0]] = 1'b1;
                        pos_next  = pos_reg + PW'(1);
                        sidx_next = sidx_reg + 4'd1;
                    end
                    else
                    begin
                        sidx_next = 4'(fdel_pkg::SUM_BYTES);
                    end
                end
                else
                begin
                    we               = 1'b1;
                    wdata            = 8'd0;
                    valid_next[pos_reg[AW-1:0]] = 1'b1;
                    res_status_next  = fdel_pkg::ST_FOUND;
                    res_cluster_next = {ent[175:160], ent[223:208]};
                    res_len_next     = pos_reg[7:0];
                    res_long_next    = 1'b0;
                    finished_next    = 1'b1;
                    state_next       = fdel_pkg::S_FIN;
                end
            end

            fdel_pkg::S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, res_byte_reg, res_long_reg, res_len_reg,
                                     res_cluster_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = fdel_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fdel_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fdel_checker.sv =====
module fdel_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");

    a_found_fields_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != fdel_pkg::ST_FOUND)) |-> (m_tdata[40:0] == '0))
        else $error("entry fields set without found status");

    a_byte_field_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != fdel_pkg::ST_BYTE)) |-> (m_tdata[55:41] == '0))
        else $error("name byte set without byte status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output changed");

endmodule

bind fat_directory_entry_lister fdel_checker u_fdel_checker (.*);

// ===== dv/lister_checker.sv =====
`timescale 1ns / 1ps

module lister_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fails,
    output int          waiting
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] cluster;
        logic [7:0]  length;
        logic        long_used;
        logic [7:0]  name_byte;
    } listing_t;

    logic [7:0]  names [fdel_pkg::NAME_BYTES];
    logic [63:0] quarters [4];
    logic [7:0]  sum_want;
    logic        lfn_live;
    logic [15:0] listed;
    logic [15:0] wanted;
    logic        done;
    logic [31:0] cluster;
    listing_t    expected_q [$];
    int          mismatches;

    assign fails = mismatches;

    function automatic void put_byte(input int p, input logic [7:0] v);
        if (p >= 0 && p < fdel_pkg::NAME_BYTES)
        begin
            names[p] = v;
        end
    endfunction

    function automatic int put_char(input int p, input logic [15:0] c);
        if (c < 16'h0080)
        begin
            put_byte(p, c[7:0]);
            return p + 1;
        end
        if (c < 16'h0800)
        begin
            put_byte(p, 8'hC0 | {3'b000, c[10:6]});
            put_byte(p + 1, 8'h80 | {2'b00, c[5:0]});
            return p + 2;
        end
        put_byte(p, 8'hE0 | {4'b0000, c[15:12]});
        put_byte(p + 1, 8'h80 | {2'b00, c[11:6]});
        put_byte(p + 2, 8'h80 | {2'b00, c[5:0]});
        return p + 3;
    endfunction

    function automatic listing_t scan_entry();
        listing_t   r;
        logic [7:0] b [32];
        logic [7:0] s;
        logic [15:0] c;
        logic       use_long;
        int         p;
        int         len;
        r = '0;
        for (int i = 0; i < 32; i++)
        begin
            b[i] = quarters[i / 8][(i % 8) * 8 +: 8];
        end
        if (b[0] == fdel_pkg::MARK_END)
        begin
            done = 1'b1;
            r.status = fdel_pkg::ST_END;
            return r;
        end
        if (b[0] == fdel_pkg::MARK_DELETED)
        begin
            return r;
        end
        if (b[11] == fdel_pkg::ATTR_LFN)
        begin
            if (b[0][6])
            begin
                for (int i = 0; i < fdel_pkg::NAME_BYTES; i++)
                begin
                    names[i] = 8'h00;
                end
                sum_want = b[13];
                lfn_live = 1'b1;
            end
            if (lfn_live && b[13] == sum_want)
            begin
                p = (int'(b[0][4:0]) - 1) * fdel_pkg::LFN_CHARS;
                for (int i = 0; i < fdel_pkg::LFN_CHARS; i++)
                begin
                    c = {b[fdel_pkg::CHAR_AT[i] + 1], b[fdel_pkg::CHAR_AT[i]]};
                    if (c != 16'hFFFF)
                    begin
                        p = put_char(p, c);
                    end
                end
            end
            return r;
        end
        s = 8'h00;
        for (int i = 0; i < fdel_pkg::SUM_BYTES; i++)
        begin
            s = {s[0], s[7:1]} + b[i];
        end
        if (lfn_live && s != sum_want)
        begin
            lfn_live = 1'b0;
        end
        if (b[11][3])
        begin
            lfn_live = 1'b0;
            return r;
        end
        if (listed == wanted)
        begin
            len = 0;
            use_long = lfn_live && names[0] != 8'h00;
            if (use_long)
            begin
                while (len < fdel_pkg::NAME_BYTES && names[len] != 8'h00)
                begin
                    len++;
                end
            end
            else
            begin
                for (int i = 0; i < 8 && b[i] != fdel_pkg::CHAR_SPACE; i++)
                begin
                    put_byte(len, b[i]);
                    len++;
                end
                if (b[8] != fdel_pkg::CHAR_SPACE)
                begin
                    put_byte(len, fdel_pkg::CHAR_DOT);
                    len++;
                    for (int i = 8; i < 11 && b[i] != fdel_pkg::CHAR_SPACE; i++)
                    begin
                        put_byte(len, b[i]);
                        len++;
                    end
                end
                put_byte(len, 8'h00);
            end
            if (len > 255)
            begin
                len = 255;
            end
            cluster = {b[21], b[20], b[27], b[26]};
            done = 1'b1;
            r.status = fdel_pkg::ST_FOUND;
            r.cluster = cluster;
            r.length = len[7:0];
            r.long_used = use_long;
            return r;
        end
        listed++;
        lfn_live = 1'b0;
        return r;
    endfunction

    function automatic listing_t predict_listing(input logic [1:0] cmd, input logic [95:0] d);
        listing_t r;
        r = '0;
        if (cmd == fdel_pkg::CMD_START)
        begin
            wanted = d[81:66];
            listed = '0;
            lfn_live = 1'b0;
            sum_want = '0;
            done = 1'b0;
            cluster = '0;
            for (int i = 0; i < fdel_pkg::NAME_BYTES; i++)
            begin
                names[i] = 8'h00;
            end
        end
        else if (cmd == fdel_pkg::CMD_ENTRY)
        begin
            quarters[d[65:64]] = d[63:0];
            if (d[65:64] == 2'd3 && !done)
            begin
                r = scan_entry();
            end
        end
        else if (cmd == fdel_pkg::CMD_READ)
        begin
            r.status = fdel_pkg::ST_BYTE;
            r.name_byte = (int'(d[89:82]) < fdel_pkg::NAME_BYTES) ? names[d[89:82]] : 8'h00;
        end
        return r;
    endfunction

    initial
    begin
        mismatches = 0;
        waiting = 0;
        for (int i = 0; i < fdel_pkg::NAME_BYTES; i++)
        begin
            names[i] = 8'h00;
        end
        for (int i = 0; i < 4; i++)
        begin
            quarters[i] = '0;
        end
        sum_want = '0;
        lfn_live = 1'b0;
        listed = '0;
        wanted = '0;
        done = 1'b0;
        cluster = '0;
    end

    always @(posedge clk)
    begin
        listing_t got;
        listing_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata[31:0], m_tdata[39:32], m_tdata[40], m_tdata[48:41]};
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected transfer: status %0d cluster %h len %0d",
                                 got.status, got.cluster, got.length);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: exp st %0d cl %h len %0d lng %0d byte %h",
                                     want.status, want.cluster, want.length,
                                     want.long_used, want.name_byte);
                            $display("          got st %0d cl %h len %0d lng %0d byte %h",
                                     got.status, got.cluster, got.length,
                                     got.long_used, got.name_byte);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_q.push_back(predict_listing(s_tuser, s_tdata));
            end
            waiting = expected_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_IDLE = 2'd3;
    localparam int ITEM_GOAL = 1450;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // entry_word[63:0], word_position[65:64],
                             // target_index[81:66], name_position[89:82]
    logic [1:0]  s_tuser;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // first_cluster[31:0], name_length[39:32],
                             // long_name_used[40], name_byte[48:41]
    logic [1:0]  m_tuser;    // status[1:0]
    int          fails;
    int          waiting;

    logic [7:0]  ent [32];
    logic [15:0] lfn_text [39];
    int          sent;
    int          burst_left;

    fat_directory_entry_lister dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    lister_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fails(fails), .waiting(waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: drive m_tready in one of four stall modes, picked at random
    initial
    begin
        int mode;
        int cyc;
        m_tready = 1'b0;
        mode = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 200 == 0)
            begin
                mode = $urandom_range(0, 3);
            end
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= (cyc % 4 == 0);
                default: m_tready <= ((cyc / 16) % 2 == 0);
            endcase
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [63:0] word, input logic [1:0] wp,
                        input logic [15:0] tgt, input logic [7:0] npos);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, npos, tgt, wp, word};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sent++;
    endtask

    task automatic send_entry();
        logic [63:0] w;
        for (int q = 0; q < 4; q++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                w[k * 8 +: 8] = ent[q * 8 + k];
            end
            send(fdel_pkg::CMD_ENTRY, w, q[1:0], 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic fill_random();
        for (int i = 0; i < 32; i++)
        begin
            ent[i] = 8'($urandom);
        end
    endtask

    task automatic make_short(input logic [7:0] attr);
        int base;
        int ext;
        fill_random();
        base = $urandom_range(1, 8);
        ext = $urandom_range(0, 3);
        for (int i = 0; i < 11; i++)
        begin
            ent[i] = fdel_pkg::CHAR_SPACE;
        end
        for (int i = 0; i < base; i++)
        begin
            ent[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h21, 8'hFF))
                                               : 8'($urandom_range(8'h41, 8'h5A));
        end
        if (ent[0] == fdel_pkg::MARK_DELETED)
        begin
            ent[0] = 8'h41;
        end
        for (int i = 0; i < ext; i++)
        begin
            ent[8 + i] = 8'($urandom_range(8'h30, 8'h5A));
        end
        ent[11] = attr;
    endtask

    function automatic logic [7:0] short_checksum();
        logic [7:0] s;
        s = 8'h00;
        for (int i = 0; i < 11; i++)
        begin
            s = {s[0], s[7:1]} + ent[i];
        end
        return s;
    endfunction

    task automatic long_group();
        logic [7:0] short_copy [32];
        logic [7:0] sum;
        logic [7:0] order;
        int pieces;
        int len;
        int kind;
        pieces = $urandom_range(1, 3);
        len = $urandom_range(1, 13 * pieces);
        for (int i = 0; i < 39; i++)
        begin
            kind = $urandom_range(0, 9);
            if (i == len)
            begin
                lfn_text[i] = 16'h0000;
            end
            else if (i > len)
            begin
                lfn_text[i] = 16'hFFFF;
            end
            else if (kind < 6)
            begin
                lfn_text[i] = 16'($urandom_range(16'h20, 16'h7E));
            end
            else if (kind < 8)
            begin
                lfn_text[i] = 16'($urandom_range(16'h80, 16'h7FF));
            end
            else if (kind < 9)
            begin
                lfn_text[i] = 16'($urandom_range(16'h800, 16'hFFFE));
            end
            else
            begin
                lfn_text[i] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            end
        end
        make_short($urandom_range(0, 3) == 0 ? 8'h10 : 8'h20);
        sum = short_checksum();
        if ($urandom_range(0, 9) == 0)
        begin
            sum = sum ^ 8'(1 << $urandom_range(0, 7));
        end
        short_copy = ent;
        for (int p = pieces; p >= 1; p--)
        begin
            fill_random();
            order = 8'(p);
            if ($urandom_range(0, 15) == 0)
            begin
                order = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(4, 31));
            end
            ent[0] = order | ((p == pieces) ? 8'h40 : 8'h00);
            ent[11] = fdel_pkg::ATTR_LFN;
            ent[12] = 8'h00;
            ent[13] = ($urandom_range(0, 19) == 0) ? 8'($urandom) : sum;
            for (int i = 0; i < fdel_pkg::LFN_CHARS; i++)
            begin
                ent[fdel_pkg::CHAR_AT[i]]     = lfn_text[(p - 1) * 13 + i][7:0];
                ent[fdel_pkg::CHAR_AT[i] + 1] = lfn_text[(p - 1) * 13 + i][15:8];
            end
            send_entry();
        end
        ent = short_copy;
        send_entry();
    endtask

    task automatic scan_pass();
        int n;
        n = $urandom_range(1, 8);
        send(fdel_pkg::CMD_START, 64'($urandom), 2'($urandom),
             ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)),
             8'($urandom));
        for (int e = 0; e < n; e++)
        begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3:
                begin
                    make_short(8'($urandom) & 8'hF7);
                    if (ent[11] == fdel_pkg::ATTR_LFN)
                    begin
                        ent[11] = 8'h20;
                    end
                    send_entry();
                end
                4, 5, 6, 7:
                begin
                    long_group();
                end
                8:
                begin
                    fill_random();
                    ent[0] = fdel_pkg::MARK_DELETED;
                    send_entry();
                end
                9:
                begin
                    make_short(8'h08);
                    send_entry();
                end
                10:
                begin
                    fill_random();
                    send_entry();
                end
                default:
                begin
                    send(($urandom_range(0, 1) == 0) ? CMD_IDLE : fdel_pkg::CMD_ENTRY,
                         {$urandom, $urandom}, 2'($urandom_range(0, 2)),
                         16'($urandom), 8'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 1) == 0)
        begin
            fill_random();
            ent[0] = fdel_pkg::MARK_END;
            send_entry();
        end
        repeat ($urandom_range(2, 8))
        begin
            send(fdel_pkg::CMD_READ, {$urandom, $urandom}, 2'($urandom), 16'($urandom),
                 ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = fdel_pkg::CMD_START;
        sent = 0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send(fdel_pkg::CMD_START, '0, '0, 16'h0000, '0);
        make_short(8'h20);
        send_entry();
        send(fdel_pkg::CMD_READ, '1, '1, '1, 8'h00);
        send(fdel_pkg::CMD_READ, '0, '0, '0, 8'hFF);
        send(CMD_IDLE, '1, '1, '1, '1);
        send(fdel_pkg::CMD_START, '1, '1, 16'hFFFF, '1);
        fill_random();
        ent[0] = fdel_pkg::MARK_DELETED;
        send_entry();
        for (int i = 0; i < 32; i++)
        begin
            ent[i] = 8'h00;
        end
        send_entry();
        for (int i = 0; i < 32; i++)
        begin
            ent[i] = 8'hFF;
        end
        send_entry();

        while (sent < ITEM_GOAL)
        begin
            scan_pass();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        guard = 0;
        while (waiting != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
        if (fails == 0 && waiting == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
